/* design/cmsg_pkg.sv */
// Package for the CAN message segmenter with transmit frame queue.
// Holds shared constants, the result kind and command codes, and the divide-by-seven helper.
// No dependencies; used by the top level and the port checker.
package cmsg_pkg;

	localparam int SEND_DEPTH_DEF = 64;
	localparam int FRAMES_W = 9;
	localparam int LEN_W = 11;
	localparam int FILL_W = 4;
	localparam int FRAME_W = 64;
	localparam int RING_W = FRAME_W + FILL_W;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 72;
	localparam int CFG_ADDR_W = 2;

	localparam logic [7:0] SEND_PERIOD_RST = 8'd5;
	localparam logic [7:0] HDR_START = 8'h80;
	localparam logic [CFG_ADDR_W-1:0] REG_SEND_PERIOD = 2'd0;

	// Reciprocal of seven scaled by 2^14; exact for every 11-bit length.
	localparam logic [11:0] DIV7_MUL = 12'd2341;
	localparam int DIV7_SHIFT = 14;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_FRAME = 2'd2
	} kind_t;

	function automatic logic [FRAMES_W-1:0] frame_count(input logic [LEN_W-1:0] len);
		logic [22:0] prod;
		prod = 23'(len) * 23'(DIV7_MUL);
		return FRAMES_W'(prod >> DIV7_SHIFT) + FRAMES_W'(1);
	endfunction

endpackage

/* design/cmsg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters; no dependencies.
// Contents are undefined until written.
module cmsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/can_message_segmenter_tx_queue_unit.sv */
// Top level of the CAN message segmenter with transmit frame queue.
// Depends on cmsg_pkg and on cmsg_ram, which holds the frame ring.
//
// Channel  Dir  Contents
// s_*      in   tuser: cmd; tdata: data_byte[7:0], first_byte[8], msg_len[19:9], tx_ready[20]
// m_*      out  tuser: kind; tdata: accepted[0], frame_len[4:1], frame_b0..frame_b7[68:5]
// p*       cfg  send_period at address 0
//
// One transaction is taken per cycle while the result is not stalled, and each gives exactly one result transaction.
// The path holds an input register, then the result register and the ring read port.
// Reset is asynchronous; the ring has no clearing pass and needs no time after reset.
// A stalled result holds in the result stage while one more input waits in the input register.
module can_message_segmenter_tx_queue_unit #(
	parameter int SEND_DEPTH = cmsg_pkg::SEND_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cmsg_pkg::S_TDATA_W-1:0]    s_tdata,  // data_byte, first_byte, msg_len, tx_ready
	input  logic                              s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cmsg_pkg::M_TDATA_W-1:0]    m_tdata,  // accepted, frame_len, frame_b0..frame_b7
	output logic [1:0]                        m_tuser,  // kind
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cmsg_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int PTR_W = $clog2(SEND_DEPTH);
	localparam int OCC_W = $clog2(SEND_DEPTH + 1);
	localparam int ROOM_W = (OCC_W > cmsg_pkg::FRAMES_W) ? OCC_W : cmsg_pkg::FRAMES_W;
	localparam int FW = cmsg_pkg::FRAME_W;
	localparam int LW = cmsg_pkg::LEN_W;
	localparam int NW = cmsg_pkg::FILL_W;

	logic                 s1_valid_q;
	logic                 cmd_s1;
	logic [7:0]           data_s1;
	logic                 first_s1;
	logic [LW-1:0]        len_s1;
	logic                 ready_s1;

	logic                 s2_valid_q;
	cmsg_pkg::kind_t      kind_s2;
	logic                 acc_s2;

	logic [PTR_W-1:0]     wptr_q, rptr_q;
	logic [OCC_W-1:0]     occ_q;
	logic [7:0]           phase_q;
	logic [1:0]           msg_id_q;
	logic [FW-1:0]        part_q;
	logic [NW-1:0]        fill_q;
	logic [7:0]           findex_q;
	logic [LW-1:0]        left_q;
	logic                 in_msg_q;
	logic [7:0]           period_q;

	logic                 advance;
	logic                 push, pop;
	logic [cmsg_pkg::RING_W-1:0] push_data, ring_rdata;
	cmsg_pkg::kind_t      kind_d;
	logic                 acc_d;
	logic [7:0]           phase_d;
	logic [1:0]           id_d;
	logic [FW-1:0]        part_d;
	logic [NW-1:0]        fill_d;
	logic [7:0]           findex_d;
	logic [LW-1:0]        left_d;
	logic                 in_msg_d;
	logic                 take;
	logic [2:0]           lane;
	logic [cmsg_pkg::FRAMES_W-1:0] frames;
	logic [ROOM_W-1:0]    room;
	logic [7:0]           period_eff;
	logic                 cfg_write;
	logic                 sent_s2;

	assign advance = s1_valid_q && (!s2_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			data_s1 <= s_tdata[7:0];
			first_s1 <= s_tdata[8];
			len_s1 <= s_tdata[19:9];
			ready_s1 <= s_tdata[20];
		end
	end

	assign frames = cmsg_pkg::frame_count(len_s1);
	assign room = ROOM_W'(SEND_DEPTH) - ROOM_W'(occ_q);
	assign period_eff = (period_q == 8'd0) ? 8'd1 : period_q;

	always_comb begin
		push = 1'b0;
		pop = 1'b0;
		push_data = '0;
		kind_d = cmsg_pkg::KIND_NONE;
		acc_d = 1'b0;
		phase_d = phase_q;
		id_d = msg_id_q;
		part_d = part_q;
		fill_d = fill_q;
		findex_d = findex_q;
		left_d = left_q;
		in_msg_d = in_msg_q;
		take = 1'b0;
		lane = 3'd0;
		if (cmd_s1 == cmsg_pkg::CMD_TICK) begin
			if (phase_q == 8'd0 && occ_q != '0 && ready_s1) begin
				pop = 1'b1;
				kind_d = cmsg_pkg::KIND_FRAME;
			end
			phase_d = ((9'(phase_q) + 9'd1) >= 9'(period_eff)) ? 8'd0 : phase_q + 8'd1;
		end else begin
			if (first_s1) begin
				if (in_msg_q) begin
					in_msg_d = 1'b0;
					part_d = '0;
					fill_d = '0;
					left_d = '0;
					id_d = msg_id_q + 2'd1;
				end
				kind_d = cmsg_pkg::KIND_STATUS;
				if (len_s1 != '0 && ROOM_W'(frames) <= room) begin
					acc_d = 1'b1;
					in_msg_d = 1'b1;
					left_d = len_s1;
					findex_d = 8'd0;
					part_d = {48'd0, frames[7:0], cmsg_pkg::HDR_START | {1'b0, id_d, 5'd0}};
					fill_d = NW'(2);
					take = 1'b1;
				end
			end else if (in_msg_q) begin
				take = 1'b1;
			end
			if (take) begin
				lane = fill_d[2:0];
				part_d = part_d | (FW'(data_s1) << {lane, 3'b000});
				fill_d = {1'b0, lane} + NW'(1);
				left_d = left_d - LW'(1);
				if (fill_d[3] || left_d == '0) begin
					push = 1'b1;
					push_data = {fill_d, part_d};
					if (left_d == '0) begin
						in_msg_d = 1'b0;
						part_d = '0;
						fill_d = '0;
						id_d = id_d + 2'd1;
					end else begin
						findex_d = findex_d + 8'd1;
						part_d = {56'd0, findex_d | {1'b0, id_d, 5'd0}};
						fill_d = NW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			occ_q <= '0;
			phase_q <= 8'd0;
			msg_id_q <= 2'd0;
			part_q <= '0;
			fill_q <= '0;
			findex_q <= 8'd0;
			left_q <= '0;
			in_msg_q <= 1'b0;
		end else if (advance) begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(SEND_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(SEND_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			occ_q <= occ_q + OCC_W'(push) - OCC_W'(pop);
			phase_q <= phase_d;
			msg_id_q <= id_d;
			part_q <= part_d;
			fill_q <= fill_d;
			findex_q <= findex_d;
			left_q <= left_d;
			in_msg_q <= in_msg_d;
		end
	end

	cmsg_ram #(
		.WIDTH(cmsg_pkg::RING_W),
		.DEPTH(SEND_DEPTH)
	) u_ring (
		.clk(clk),
		.we(advance && push),
		.waddr(wptr_q),
		.wdata(push_data),
		.re(advance && pop),
		.raddr(rptr_q),
		.rdata(ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (advance) begin
			s2_valid_q <= 1'b1;
		end else if (m_tready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2 <= kind_d;
			acc_s2 <= acc_d;
		end
	end

	assign sent_s2 = (kind_s2 == cmsg_pkg::KIND_FRAME);
	assign m_tvalid = s2_valid_q;
	assign m_tuser = kind_s2;
	assign m_tdata = {3'b000,
		sent_s2 ? ring_rdata[FW-1:0] : {FW{1'b0}},
		sent_s2 ? ring_rdata[cmsg_pkg::RING_W-1:FW] : {NW{1'b0}},
		acc_s2};

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata = {24'd0, period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= cmsg_pkg::SEND_PERIOD_RST;
		end else if (cfg_write && paddr == cmsg_pkg::REG_SEND_PERIOD) begin
			period_q <= pwdata[7:0];
		end
	end

endmodule

/* design/cmsg_checker.sv */
// Port-level checker for the CAN message segmenter top level, bound to every instance.
// Depends on cmsg_pkg for the result kind codes.
// Sees only the ports of the top level.
module cmsg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cmsg_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [1:0]                        m_tuser
);

	// A stalled result transaction holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a sent frame carries a length or frame bytes.
	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cmsg_pkg::KIND_FRAME |-> m_tdata[71:1] == '0)
		else $error("frame fields set on a result that is not a frame");

	// A sent frame holds a header and at least one payload byte, at most eight bytes.
	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cmsg_pkg::KIND_FRAME |->
		m_tdata[4:1] >= 4'd2 && m_tdata[4:1] <= 4'd8 && !m_tdata[0])
		else $error("frame length out of range");

	// Byte slot frame_b7 of a frame shorter than eight bytes is zero.
	a_frame_tail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cmsg_pkg::KIND_FRAME && m_tdata[4:1] < 4'd8 |->
		m_tdata[68:61] == 8'd0)
		else $error("data beyond frame length");

endmodule

bind can_message_segmenter_tx_queue_unit cmsg_checker u_cmsg_checker (.*);

/* test/tb_can_message_segmenter_tx_queue_unit.sv */
// Testbench for can_message_segmenter_tx_queue_unit: directed table, then random message traffic.
// Each output is checked against a fixed table row or a model of the segmenter and frame ring.
// Depends on cmsg_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_can_message_segmenter_tx_queue_unit;

	localparam int DEPTH = cmsg_pkg::SEND_DEPTH_DEF;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 120;
	// A period of -1 picks a random one.
	localparam int PH_PERIOD [PHASES] = '{1, 255, 128, 3, 1, 0, -1, 2, 7, 1};
	localparam int PH_TICK [PHASES] = '{40, 20, 20, 10, 60, 40, 30, 30, 50, 50};
	localparam int PH_READY [PHASES] = '{90, 100, 10, 0, 100, 80, 70, 60, 90, 100};
	localparam bit PH_NO_STALL [PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

	typedef struct {
		logic        cmd;
		logic [7:0]  data;
		logic        first;
		logic [10:0] len;
		logic        ready;
	} seg_item_t;

	typedef struct {
		cmsg_pkg::kind_t kind;
		logic        accepted;
		logic [3:0]  flen;
		logic [63:0] frame;
	} seg_result_t;

	typedef struct {
		seg_item_t it;
		bit        fixed;
		cmsg_pkg::kind_t kind;
		logic      acc;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [cmsg_pkg::S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [cmsg_pkg::M_TDATA_W-1:0]  m_tdata;
	logic [1:0]            m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [cmsg_pkg::CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	can_message_segmenter_tx_queue_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Model state of the segmenter and its frame ring.
	logic [63:0] ring_frame [DEPTH];
	logic [3:0]  ring_fill [DEPTH];
	int          wr_idx = 0;
	int          rd_idx = 0;
	int          frames_queued = 0;
	int          tick_count = 0;
	int          remaining = 0;
	int          build_fill = 0;
	int          build_index = 0;
	logic [1:0]  msg_id = '0;
	logic [63:0] build_frame = '0;
	bit          msg_open = 0;
	logic [7:0]  period_reg = cmsg_pkg::SEND_PERIOD_RST;

	seg_result_t expected_frames [$];
	seg_result_t blank_result;
	int          mismatch_count = 0;
	int          counted_items = 0;
	bit          no_stall = 0;
	int          tick_pct = 30;
	int          ready_pct = 80;

	function automatic void queue_built_frame();
		ring_frame[wr_idx] = build_frame;
		ring_fill[wr_idx] = 4'(build_fill);
		wr_idx = (wr_idx + 1 >= DEPTH) ? 0 : wr_idx + 1;
		frames_queued++;
	endfunction

	function automatic void close_message();
		msg_open = 0;
		build_frame = '0;
		build_fill = 0;
		remaining = 0;
		msg_id = msg_id + 2'd1;
	endfunction

	function automatic void append_byte(logic [7:0] b);
		int fill;
		fill = build_fill % 8;
		build_frame |= 64'(b) << (8 * fill);
		build_fill = fill + 1;
		remaining = (remaining - 1) & 'h7FF;
		if (build_fill >= 8 || remaining == 0) begin
			queue_built_frame();
			if (remaining == 0) begin
				close_message();
			end else begin
				build_index = (build_index + 1) & 'hFF;
				build_frame = 64'((8'(msg_id) << 5) | 8'(build_index));
				build_fill = 1;
			end
		end
	endfunction

	function automatic seg_result_t predict_segmenter(seg_item_t it);
		seg_result_t res;
		int per;
		int frames;
		res.kind = cmsg_pkg::KIND_NONE;
		res.accepted = 1'b0;
		res.flen = '0;
		res.frame = '0;
		if (it.cmd == cmsg_pkg::CMD_TICK) begin
			per = (period_reg == 8'd0) ? 1 : int'(period_reg);
			if (tick_count == 0 && frames_queued > 0 && it.ready) begin
				res.kind = cmsg_pkg::KIND_FRAME;
				res.flen = ring_fill[rd_idx];
				res.frame = ring_frame[rd_idx];
				rd_idx = (rd_idx + 1 >= DEPTH) ? 0 : rd_idx + 1;
				frames_queued--;
			end
			tick_count = (tick_count + 1 >= per) ? 0 : tick_count + 1;
		end else if (it.first) begin
			frames = 1 + int'(it.len) / 7;
			if (msg_open)
				close_message();
			res.kind = cmsg_pkg::KIND_STATUS;
			if (it.len != 0 && frames <= DEPTH - frames_queued) begin
				res.accepted = 1'b1;
				msg_open = 1;
				remaining = int'(it.len);
				build_index = 0;
				build_frame = {48'd0, 8'(frames), cmsg_pkg::HDR_START | (8'(msg_id) << 5)};
				build_fill = 2;
				append_byte(it.data);
			end
		end else if (msg_open) begin
			append_byte(it.data);
		end
		return res;
	endfunction

	function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, field, want, got);
	endfunction

	function automatic void check_result(logic [1:0] kind_bits,
			logic [cmsg_pkg::M_TDATA_W-1:0] bits);
		seg_result_t want;
		if (expected_frames.size() == 0) begin
			note_mismatch("transaction with none expected", 64'd0, 64'(kind_bits));
			return;
		end
		want = expected_frames.pop_front();
		if (kind_bits !== want.kind)
			note_mismatch("kind", 64'(want.kind), 64'(kind_bits));
		if (bits[0] !== want.accepted)
			note_mismatch("accepted", 64'(want.accepted), 64'(bits[0]));
		if (bits[4:1] !== want.flen)
			note_mismatch("frame_len", 64'(want.flen), 64'(bits[4:1]));
		for (int i = 0; i < 8; i++) begin
			if (bits[5 + 8 * i +: 8] !== want.frame[8 * i +: 8])
				note_mismatch($sformatf("frame_b%0d", i), 64'(want.frame[8 * i +: 8]),
					64'(bits[5 + 8 * i +: 8]));
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[can_message_segmenter_tx_queue_unit] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(m_tuser, m_tdata);
			m_tready <= no_stall || ($urandom_range(99) >= 27);
		end else begin
			m_tready <= 1'b0;
		end
	end

	task automatic push_item(seg_item_t it, bit fixed, seg_result_t want);
		seg_result_t got;
		if (!no_stall && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 27);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {3'b000, it.ready, it.len, it.first, it.data};
		do @(posedge clk); while (!s_tready);
		if (it.cmd == cmsg_pkg::CMD_TICK || it.first || msg_open)
			counted_items++;
		got = predict_segmenter(it);
		expected_frames.push_back(fixed ? want : got);
	endtask

	task automatic send_random(logic cmd, logic first, logic [10:0] len);
		seg_item_t it;
		it.cmd = cmd;
		it.data = 8'($urandom_range(255));
		it.first = first;
		it.len = len;
		it.ready = ($urandom_range(99) < ready_pct);
		push_item(it, 0, blank_result);
	endtask

	task automatic send_ticks();
		while ($urandom_range(99) < tick_pct)
			send_random(cmsg_pkg::CMD_TICK, 1'($urandom_range(1)), 11'($urandom_range(2047)));
	endtask

	function automatic logic [10:0] pick_msg_len();
		int r;
		r = $urandom_range(99);
		if (r < 2)
			return 11'd0;
		if (r < 55)
			return 11'($urandom_range(1, 13));
		if (r < 80)
			return 11'($urandom_range(14, 60));
		if (r < 90)
			return 11'($urandom_range(61, 255));
		if (r < 95)
			return 11'($urandom_range(256, 447));
		return 11'($urandom_range(448, 1784));
	endfunction

	// A whole message with ticks mixed in; some are cut short and abandoned by the next one.
	task automatic send_message(logic [10:0] len);
		bit admit;
		int n;
		admit = (len != 0) && (1 + int'(len) / 7 <= DEPTH - frames_queued);
		n = admit ? int'(len) : $urandom_range(1, 4);
		if (admit && len > 2 && $urandom_range(99) < 6)
			n = $urandom_range(1, int'(len) - 1);
		send_random(cmsg_pkg::CMD_DATA, 1'b1, len);
		for (int k = 1; k < n; k++) begin
			send_ticks();
			send_random(cmsg_pkg::CMD_DATA, 1'b0, 11'($urandom_range(2047)));
		end
		send_ticks();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= cmsg_pkg::REG_SEND_PERIOD;
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		period_reg = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(value))
			note_mismatch("send_period readback", 64'(value), 64'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic stim_row_t stim_row(logic cmd, logic [7:0] data, logic first,
			logic [10:0] len, logic ready, bit fixed, cmsg_pkg::kind_t kind, logic acc);
		stim_row_t r;
		r.it.cmd = cmd;
		r.it.data = data;
		r.it.first = first;
		r.it.len = len;
		r.it.ready = ready;
		r.fixed = fixed;
		r.kind = kind;
		r.acc = acc;
		return r;
	endfunction

	initial begin
		stim_row_t   rows [$];
		seg_result_t want;
		int          per;

		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= cmsg_pkg::CMD_DATA;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		blank_result.kind = cmsg_pkg::KIND_NONE;
		blank_result.accepted = 1'b0;
		blank_result.flen = '0;
		blank_result.frame = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(stim_row(cmsg_pkg::CMD_TICK, 8'h00, 0, 11'd0, 1, 1,
			cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'hFF, 0, 11'd0, 1, 1,
			cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h00, 1, 11'd0, 0, 1,
			cmsg_pkg::KIND_STATUS, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h80, 0, 11'd0, 0, 1,
			cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'hFF, 1, 11'd1784, 1, 1,
			cmsg_pkg::KIND_STATUS, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h3C, 1, 11'd2047, 0, 1,
			cmsg_pkg::KIND_STATUS, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h00, 1, 11'd1, 0, 1,
			cmsg_pkg::KIND_STATUS, 1));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'hFF, 1, 11'd7, 1, 1,
			cmsg_pkg::KIND_STATUS, 1));
		for (int i = 1; i <= 6; i++)
			rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'(i * 'h11), 0, 11'd0, 0, 0,
				cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h5A, 1, 11'd20, 0, 1,
			cmsg_pkg::KIND_STATUS, 1));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'hC3, 0, 11'd0, 0, 0,
			cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h77, 1, 11'd3, 1, 1,
			cmsg_pkg::KIND_STATUS, 1));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h88, 0, 11'd0, 0, 0,
			cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_DATA, 8'h99, 0, 11'd0, 0, 0,
			cmsg_pkg::KIND_NONE, 0));
		for (int i = 0; i < 5; i++)
			rows.push_back(stim_row(cmsg_pkg::CMD_TICK, 8'h00, 0, 11'd0, 1, 0,
				cmsg_pkg::KIND_NONE, 0));
		rows.push_back(stim_row(cmsg_pkg::CMD_TICK, 8'hFF, 1, 11'd2047, 0, 0,
			cmsg_pkg::KIND_NONE, 0));

		foreach (rows[i]) begin
			want.kind = rows[i].kind;
			want.accepted = rows[i].acc;
			want.flen = '0;
			want.frame = '0;
			push_item(rows[i].it, rows[i].fixed, want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			per = (PH_PERIOD[ph] < 0) ? $urandom_range(1, 255) : PH_PERIOD[ph];
			write_period(8'(per));
			tick_pct = PH_TICK[ph];
			ready_pct = PH_READY[ph];
			no_stall = PH_NO_STALL[ph];
			counted_items = 0;
			while (counted_items < PHASE_ITEMS) begin
				if ($urandom_range(99) < 6) begin
					if ($urandom_range(1))
						send_random(cmsg_pkg::CMD_DATA, 1'b0, 11'($urandom_range(2047)));
					else
						send_random(cmsg_pkg::CMD_TICK, 1'($urandom_range(1)),
							11'($urandom_range(2047)));
				end else begin
					send_message(pick_msg_len());
				end
			end
			no_stall = 0;
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[can_message_segmenter_tx_queue_unit] OK");
		end else begin
			$display("[can_message_segmenter_tx_queue_unit] ERROR");
		end
		$finish;
	end

endmodule
